/* hw/rtl/virtual_sync_generator_control_top_assert.svh */
// ----------------------------------------------------------------------------
// VSG control assertion macros
// Short forms for same-cycle and next-cycle implications under reset.
// ----------------------------------------------------------------------------
`ifndef VIRTUAL_SYNC_GENERATOR_CONTROL_TOP_ASSERT_SVH
`define VIRTUAL_SYNC_GENERATOR_CONTROL_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VSGC_ASSERT_SAME(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define VSGC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vsgc_pkg.sv */
// ----------------------------------------------------------------------------
// VSG control package
// Widths, fixed-point constants, saturation helpers and the CORDIC table.
// ----------------------------------------------------------------------------
package vsgc_pkg;

  localparam int IN_W       = 224;
  localparam int OUT_W      = 328;
  localparam int WIDE_W     = 50;   // rounded product before saturation
  localparam int NUM_W      = 49;   // divider dividend magnitude
  localparam int DEN_W      = 47;   // divider divisor / remainder
  localparam int NUM_ACC_W  = 35;   // sum of three saturated terms
  localparam int CW         = 20;   // CORDIC datapath
  localparam int ANG_W      = 21;   // reduced angle
  localparam int TRIG_W     = 18;
  localparam int MUL_STEPS  = 32;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic [31:0] K_VOLT   = 32'd13150598;
  localparam logic [31:0] K_CURR   = 32'd105201567;
  localparam logic [31:0] K_OMEGA  = 32'd13671306;
  localparam logic [31:0] K_NEW    = 32'd85899346;
  localparam logic [31:0] K_OLD    = 32'd4209067950;
  localparam logic [31:0] AMPS_Q16 = 32'd2675494;
  localparam int TWO_PI_Q16  = 411775;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int CORDIC_X0   = 39796;
  localparam int TRIG_ONE    = 65536;

  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(64'sh7FFF_FFFF);
  localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-64'sh8000_0000);

  typedef enum logic {MUL_Q16, MUL_C32} mul_mode_t;

  typedef struct packed {
    logic      start;
    mul_mode_t mode;
  } mul_req_t;

  typedef enum logic [2:0] {
    REG_KP_ACTIVE, REG_KI_TS_ACTIVE, REG_KP_REACTIVE, REG_KI_TS_REACTIVE,
    REG_OMEGA_BASE, REG_STEP_TIME, REG_VIRT_RESISTANCE, REG_VIRT_REACTANCE
  } cfg_reg_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7FFF_FFFF;
    else if (v < SAT_LO) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(WIDE_W'(a) + WIDE_W'(b));
  endfunction

  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(WIDE_W'(a) - WIDE_W'(b));
  endfunction

  // arctan(2^-i) in Q16.16
  function automatic logic signed [CW-1:0] atan_q16(input logic [3:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      4'd0:  r = 20'sd51472;
      4'd1:  r = 20'sd30386;
      4'd2:  r = 20'sd16055;
      4'd3:  r = 20'sd8150;
      4'd4:  r = 20'sd4091;
      4'd5:  r = 20'sd2047;
      4'd6:  r = 20'sd1024;
      4'd7:  r = 20'sd512;
      4'd8:  r = 20'sd256;
      4'd9:  r = 20'sd128;
      4'd10: r = 20'sd64;
      4'd11: r = 20'sd32;
      4'd12: r = 20'sd16;
      4'd13: r = 20'sd8;
      4'd14: r = 20'sd4;
      4'd15: r = 20'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/vsgc_sermul.sv */
// ----------------------------------------------------------------------------
// VSG serial multiplier
// Bit-serial shift-add multiply, one multiplier bit per cycle, then a
// rounding step for Q16.16 or Q0.32 scaling and 32-bit saturation.
// ----------------------------------------------------------------------------
module vsgc_sermul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vsgc_pkg::mul_req_t                  req,
  input  logic signed [32:0]                  op_a,
  input  logic signed [32:0]                  op_b,
  output logic                                done,
  output logic signed [vsgc_pkg::WIDE_W-1:0]  res_wide,
  output logic signed [31:0]                  res_sat
);

  logic                               busy_r, fin_r, done_r, neg_r;
  logic [4:0]                         cnt_r;
  logic [63:0]                        acc_r;
  logic [31:0]                        mag_a_r;
  vsgc_pkg::mul_mode_t                mode_r;
  logic signed [vsgc_pkg::WIDE_W-1:0] res_wide_r;
  logic signed [31:0]                 res_sat_r;

  logic [31:0]                        mag_a, mag_b;
  logic [32:0]                        psum;
  logic signed [64:0]                 prod;
  logic signed [65:0]                 rsum, shifted;
  logic signed [vsgc_pkg::WIDE_W-1:0] wide;

  always_comb begin
    mag_a   = op_a[32] ? 32'(-op_a) : op_a[31:0];
    mag_b   = op_b[32] ? 32'(-op_b) : op_b[31:0];
    // add into the upper half, then shift the partial product right
    psum    = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, mag_a_r} : 33'd0);
    prod    = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
    rsum    = 66'(prod) + ((mode_r == vsgc_pkg::MUL_C32) ? 66'sd2147483648 : 66'sd32768);
    shifted = (mode_r == vsgc_pkg::MUL_C32) ? (rsum >>> 32) : (rsum >>> 16);
    wide    = shifted[vsgc_pkg::WIDE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        acc_r   <= {32'd0, mag_b};
        mag_a_r <= mag_a;
        neg_r   <= op_a[32] ^ op_b[32];
        mode_r  <= req.mode;
      end else if (busy_r) begin
        acc_r <= {psum, acc_r[31:1]};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(vsgc_pkg::MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        done_r     <= 1'b1;
        res_wide_r <= wide;
        res_sat_r  <= vsgc_pkg::sat32(wide);
      end
    end
  end

  assign done     = done_r;
  assign res_wide = res_wide_r;
  assign res_sat  = res_sat_r;

endmodule

/* hw/rtl/vsgc_serdiv.sv */
// ----------------------------------------------------------------------------
// VSG serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vsgc_serdiv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [vsgc_pkg::NUM_W-1:0]       dividend,
  input  logic [vsgc_pkg::DEN_W-1:0]       divisor,
  output logic                             done,
  output logic [vsgc_pkg::NUM_W-1:0]       quo,
  output logic [vsgc_pkg::DEN_W-1:0]       rem
);

  logic                         busy_r, done_r;
  logic [5:0]                   cnt_r;
  logic [vsgc_pkg::NUM_W-1:0]   n_r;
  logic [vsgc_pkg::DEN_W-1:0]   r_r, d_r;

  logic [vsgc_pkg::DEN_W:0]     trial;
  logic                         ge;
  logic [vsgc_pkg::DEN_W-1:0]   r_nxt;

  always_comb begin
    trial = {r_r, n_r[vsgc_pkg::NUM_W-1]};
    ge    = trial >= {1'b0, d_r};
    r_nxt = ge ? vsgc_pkg::DEN_W'(trial - {1'b0, d_r}) : trial[vsgc_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        // dividend bits leave at the top, quotient bits enter at the bottom
        n_r   <= {n_r[vsgc_pkg::NUM_W-2:0], ge};
        r_r   <= r_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(vsgc_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = n_r;
  assign rem  = r_r;

endmodule

/* hw/rtl/vsgc_cordic.sv */
// ----------------------------------------------------------------------------
// VSG CORDIC sine/cosine
// Folds a reduced angle into [-pi/2, pi/2], then 16 rotation steps, one
// per cycle, with a final sign fix and clamp to +-1.0.
// ----------------------------------------------------------------------------
module vsgc_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [vsgc_pkg::ANG_W-1:0]   angle,
  output logic                                done,
  output logic signed [vsgc_pkg::TRIG_W-1:0]  sine,
  output logic signed [vsgc_pkg::TRIG_W-1:0]  cosine
);

  localparam logic signed [vsgc_pkg::ANG_W-1:0] A_2PI  = vsgc_pkg::ANG_W'(vsgc_pkg::TWO_PI_Q16);
  localparam logic signed [vsgc_pkg::ANG_W-1:0] A_PI   = vsgc_pkg::ANG_W'(vsgc_pkg::PI_Q16);
  localparam logic signed [vsgc_pkg::ANG_W-1:0] A_HALF = vsgc_pkg::ANG_W'(vsgc_pkg::HALF_PI_Q16);
  localparam logic signed [vsgc_pkg::CW-1:0]    C_ONE  = vsgc_pkg::CW'(vsgc_pkg::TRIG_ONE);

  logic                               busy_r, fin_r, done_r, negc_r;
  logic [3:0]                         i_r;
  logic signed [vsgc_pkg::CW-1:0]     x_r, y_r, z_r;
  logic signed [vsgc_pkg::TRIG_W-1:0] sine_r, cosine_r;

  logic signed [vsgc_pkg::ANG_W-1:0]  r1, r2, z0;
  logic                               negc;
  logic signed [vsgc_pkg::CW-1:0]     dx, dy, xf;

  function automatic logic signed [vsgc_pkg::TRIG_W-1:0] clamp1(
      input logic signed [vsgc_pkg::CW-1:0] v);
    logic signed [vsgc_pkg::CW-1:0] c;
    if (v > C_ONE) c = C_ONE;
    else if (v < -C_ONE) c = -C_ONE;
    else c = v;
    return c[vsgc_pkg::TRIG_W-1:0];
  endfunction

  always_comb begin
    r1 = (angle < 0) ? angle + A_2PI : angle;
    r2 = (r1 > A_PI) ? r1 - A_2PI : r1;
    negc = 1'b1;
    if (r2 > A_HALF) z0 = A_PI - r2;
    else if (r2 < -A_HALF) z0 = -A_PI - r2;
    else begin
      z0   = r2;
      negc = 1'b0;
    end
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    xf = negc_r ? -x_r : x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        x_r    <= vsgc_pkg::CW'(vsgc_pkg::CORDIC_X0);
        y_r    <= '0;
        z_r    <= z0[vsgc_pkg::CW-1:0];
        negc_r <= negc;
      end else if (busy_r) begin
        if (z_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - vsgc_pkg::atan_q16(i_r);
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + vsgc_pkg::atan_q16(i_r);
        end
        i_r <= i_r + 4'd1;
        if (i_r == 4'(vsgc_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        done_r   <= 1'b1;
        sine_r   <= clamp1(y_r);
        cosine_r <= clamp1(xf);
      end
    end
  end

  assign done   = done_r;
  assign sine   = sine_r;
  assign cosine = cosine_r;

endmodule

/* hw/rtl/virtual_sync_generator_control_top.sv */
// ----------------------------------------------------------------------------
// Virtual synchronous generator P/Q droop control
// Each word runs through 30 bit-serial multiplies, three serial divides (two
// impedance quotients, one angle modulo) and a CORDIC, all on one sequencer;
// one word is in work at a time, and the next word is taken while a result waits.
// Synchronous active-low reset restores register defaults and clears the
// sequencer, output valid, integrators, phase angle and filter state.
`include "virtual_sync_generator_control_top_assert.svh"

module virtual_sync_generator_control_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // voltage_d, voltage_q, current_d, current_q, pll_omega, p_reference, q_reference
  input  logic [vsgc_pkg::IN_W-1:0]    in_tdata,
  // run_mode
  input  logic [0:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // active_power, reactive_power, virtual_speed, phase_angle, phase_sine(18),
  // phase_cosine(18), voltage_delta, emf_out, current_ref_d, current_ref_q,
  // filtered_speed, 4 zero bits
  output logic [vsgc_pkg::OUT_W-1:0]   out_tdata,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [31:0]                  cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE, S_VD, S_VQ, S_ID, S_IQ, S_W0, S_P1, S_P2, S_Q1, S_Q2, S_KP, S_OM, S_KR,
    S_RR, S_XX, S_ND1, S_ND2, S_ND3, S_NQ1, S_NQ2, S_NQ3, S_DD, S_DQ,
    S_FD1, S_FD2, S_FQ1, S_FQ2, S_SI, S_VI, S_PH, S_AD, S_AQ, S_FS,
    S_MOD, S_COR, S_OUT
  } step_t;

  localparam logic signed [31:0] P_2PI = 32'(vsgc_pkg::TWO_PI_Q16);

  // configuration
  logic [30:0] kp_a_r, ki_a_r, kp_r_r, ki_r_r, ob_r, rv_r, xv_r;
  logic [31:0] ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_a_r <= 31'd65536;
      ki_a_r <= '0;
      kp_r_r <= 31'd65536;
      ki_r_r <= '0;
      ob_r   <= 31'd20588742;
      ts_r   <= 32'd429497;
      rv_r   <= '0;
      xv_r   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (vsgc_pkg::cfg_reg_t'(cfg_addr))
        vsgc_pkg::REG_KP_ACTIVE:       kp_a_r <= cfg_wdata[30:0];
        vsgc_pkg::REG_KI_TS_ACTIVE:    ki_a_r <= cfg_wdata[30:0];
        vsgc_pkg::REG_KP_REACTIVE:     kp_r_r <= cfg_wdata[30:0];
        vsgc_pkg::REG_KI_TS_REACTIVE:  ki_r_r <= cfg_wdata[30:0];
        vsgc_pkg::REG_OMEGA_BASE:      ob_r   <= cfg_wdata[30:0];
        vsgc_pkg::REG_STEP_TIME:       ts_r   <= cfg_wdata;
        vsgc_pkg::REG_VIRT_RESISTANCE: rv_r   <= cfg_wdata[30:0];
        vsgc_pkg::REG_VIRT_REACTANCE:  xv_r   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  step_t st_r;
  logic  launched_r, out_valid_r, run_r;
  logic signed [31:0] vdin_r, vqin_r, idin_r, iqin_r, pll_r, pref_r, qref_r, theta_r;
  logic signed [31:0] vd_r, vq_r, id_r, iq_r, w0_r, t1_r, p_r, q_r, om_r, dv_r;
  logic signed [31:0] zd_r, zq_r, crd_r, crq_r, fs_r;
  logic signed [31:0] si_r, vi_r, pa_r, pd_r, pq_r;
  logic [vsgc_pkg::DEN_W-1:0] den_r;
  logic signed [vsgc_pkg::NUM_ACC_W-1:0] nd_r, nq_r;
  logic signed [vsgc_pkg::ANG_W-1:0] ang_r;
  logic [vsgc_pkg::OUT_W-1:0] out_data_r;

  // unit interfaces
  vsgc_pkg::mul_req_t mul_req;
  logic signed [32:0] op_a, op_b;
  logic mul_done, div_start, div_done, cor_start, cor_done;
  logic signed [vsgc_pkg::WIDE_W-1:0] mul_wide;
  logic signed [31:0] mul_sat;
  logic [vsgc_pkg::NUM_W-1:0] div_dividend, div_quo;
  logic [vsgc_pkg::DEN_W-1:0] div_divisor, div_rem;
  logic signed [vsgc_pkg::TRIG_W-1:0] sine, cosine;

  logic is_div, is_cor, busy_step, go, unit_done;
  logic signed [31:0] ob_s, ep, eq, e, w0_sel, pa_wrap, emf, zval;
  logic signed [vsgc_pkg::NUM_ACC_W-1:0] num_sel, num_mag;
  logic [31:0] theta_mag;
  logic signed [vsgc_pkg::WIDE_W-1:0] quo_s;
  logic signed [vsgc_pkg::ANG_W-1:0] rem_s;

  always_comb begin
    ob_s    = $signed({1'b0, ob_r});
    ep      = vsgc_pkg::ssub(pref_r, p_r);
    eq      = vsgc_pkg::ssub(qref_r, q_r);
    e       = vsgc_pkg::sadd(vsgc_pkg::ONE_Q16, dv_r);
    emf     = vsgc_pkg::sat32(-vsgc_pkg::WIDE_W'(e));
    w0_sel  = run_r ? vsgc_pkg::ONE_Q16 : w0_r;
    if (pa_r > P_2PI) pa_wrap = pa_r - P_2PI;
    else if (pa_r < -P_2PI) pa_wrap = pa_r + P_2PI;
    else pa_wrap = pa_r;

    is_div    = (st_r == S_DD) || (st_r == S_DQ) || (st_r == S_MOD);
    is_cor    = (st_r == S_COR);
    busy_step = (st_r != S_IDLE) && (st_r != S_OUT);
    go        = busy_step && !launched_r;
    unit_done = is_div ? div_done : (is_cor ? cor_done : mul_done);

    // impedance quotient: -(num*65536)/den, truncated toward zero
    num_sel   = (st_r == S_DQ) ? nq_r : nd_r;
    num_mag   = num_sel[vsgc_pkg::NUM_ACC_W-1] ? -num_sel : num_sel;
    theta_mag = theta_r[31] ? 32'(-theta_r) : theta_r;
    quo_s     = $signed(vsgc_pkg::WIDE_W'(div_quo));
    if (den_r == '0) zval = '0;
    else if (num_sel[vsgc_pkg::NUM_ACC_W-1]) zval = vsgc_pkg::sat32(quo_s);
    else zval = vsgc_pkg::sat32(-quo_s);
    rem_s     = $signed(vsgc_pkg::ANG_W'(div_rem));

    if (st_r == S_MOD) begin
      div_dividend = vsgc_pkg::NUM_W'(theta_mag);
      div_divisor  = vsgc_pkg::DEN_W'(vsgc_pkg::TWO_PI_Q16);
    end else begin
      div_dividend = {num_mag[32:0], 16'h0000};
      div_divisor  = den_r;
    end
    div_start = go && is_div;
    cor_start = go && is_cor;

    mul_req.start = go && !is_div && !is_cor;
    mul_req.mode  = vsgc_pkg::MUL_Q16;
    op_a = '0;
    op_b = '0;
    unique case (st_r)
      S_VD:  begin op_a = 33'(vdin_r); op_b = 33'(vsgc_pkg::K_VOLT);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_VQ:  begin op_a = 33'(vqin_r); op_b = 33'(vsgc_pkg::K_VOLT);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_ID:  begin op_a = 33'(idin_r); op_b = 33'(vsgc_pkg::K_CURR);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_IQ:  begin op_a = 33'(iqin_r); op_b = 33'(vsgc_pkg::K_CURR);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_W0:  begin op_a = 33'(pll_r); op_b = 33'(vsgc_pkg::K_OMEGA);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_P1:  begin op_a = 33'(id_r); op_b = 33'(vd_r); end
      S_P2:  begin op_a = 33'(iq_r); op_b = 33'(vq_r); end
      S_Q1:  begin op_a = 33'(id_r); op_b = 33'(vq_r); end
      S_Q2:  begin op_a = 33'(iq_r); op_b = 33'(vd_r); end
      S_KP:  begin op_a = 33'(kp_a_r); op_b = 33'(ep); end
      S_OM:  begin op_a = 33'(t1_r); op_b = 33'(ob_r); end
      S_KR:  begin op_a = 33'(kp_r_r); op_b = 33'(eq); end
      S_RR:  begin op_a = 33'(rv_r); op_b = 33'(rv_r); end
      S_XX:  begin op_a = 33'(xv_r); op_b = 33'(xv_r); end
      S_ND1: begin op_a = 33'(xv_r); op_b = 33'(e); end
      S_ND2: begin op_a = 33'(rv_r); op_b = 33'(vd_r); end
      S_ND3: begin op_a = 33'(xv_r); op_b = 33'(vq_r); end
      S_NQ1: begin op_a = 33'(rv_r); op_b = 33'(e); end
      S_NQ2: begin op_a = 33'(rv_r); op_b = 33'(vq_r); end
      S_NQ3: begin op_a = 33'(xv_r); op_b = 33'(vd_r); end
      S_FD1: begin op_a = 33'(zd_r); op_b = 33'(vsgc_pkg::K_NEW);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_FD2: begin op_a = 33'(pd_r); op_b = 33'(vsgc_pkg::K_OLD);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_FQ1: begin op_a = 33'(zq_r); op_b = 33'(vsgc_pkg::K_NEW);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_FQ2: begin op_a = 33'(pq_r); op_b = 33'(vsgc_pkg::K_OLD);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_SI:  begin op_a = 33'(ki_a_r); op_b = 33'(ep); end
      S_VI:  begin op_a = 33'(ki_r_r); op_b = 33'(eq); end
      S_PH:  begin op_a = 33'(om_r); op_b = 33'(ts_r);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      S_AD:  begin op_a = 33'(pd_r); op_b = 33'(vsgc_pkg::AMPS_Q16); end
      S_AQ:  begin op_a = 33'(pq_r); op_b = 33'(vsgc_pkg::AMPS_Q16); end
      S_FS:  begin op_a = 33'(vsgc_pkg::ssub(om_r, ob_s)); op_b = 33'(ts_r);
                   mul_req.mode = vsgc_pkg::MUL_C32; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      si_r        <= '0;
      vi_r        <= '0;
      pa_r        <= '0;
      pd_r        <= '0;
      pq_r        <= '0;
    end else begin
      // in the output step the word is replaced rather than dropped
      if (out_valid_r && out_tready && (st_r != S_OUT)) out_valid_r <= 1'b0;
      if (st_r == S_IDLE) begin
        if (in_tvalid) begin
          vdin_r  <= in_tdata[31:0];
          vqin_r  <= in_tdata[63:32];
          idin_r  <= in_tdata[95:64];
          iqin_r  <= in_tdata[127:96];
          pll_r   <= in_tdata[159:128];
          pref_r  <= in_tdata[191:160];
          qref_r  <= in_tdata[223:192];
          run_r   <= in_tuser[0];
          theta_r <= pa_r;
          st_r    <= S_VD;
        end
      end else if (st_r == S_OUT) begin
        if (!out_valid_r || out_tready) begin
          out_data_r  <= {4'h0, fs_r, crq_r, crd_r, emf, dv_r, cosine, sine,
                          theta_r, om_r, q_r, p_r};
          out_valid_r <= 1'b1;
          st_r        <= S_IDLE;
        end
      end else if (!launched_r) begin
        launched_r <= 1'b1;
      end else if (unit_done) begin
        launched_r <= 1'b0;
        st_r       <= step_t'(st_r + 6'd1);
        unique case (st_r)
          S_VD:  vd_r <= mul_sat;
          S_VQ:  vq_r <= mul_sat;
          S_ID:  id_r <= mul_sat;
          S_IQ:  iq_r <= mul_sat;
          S_W0:  w0_r <= mul_sat;
          S_P1:  t1_r <= mul_sat;
          S_P2:  p_r  <= vsgc_pkg::sadd(t1_r, mul_sat);
          S_Q1:  t1_r <= mul_sat;
          S_Q2:  q_r  <= vsgc_pkg::ssub(t1_r, mul_sat);
          S_KP:  t1_r <= vsgc_pkg::sadd(vsgc_pkg::sadd(mul_sat, si_r), w0_sel);
          S_OM:  om_r <= mul_sat;
          S_KR:  dv_r <= vsgc_pkg::sadd(mul_sat, vi_r);
          S_RR:  den_r <= vsgc_pkg::DEN_W'(mul_wide);
          S_XX:  den_r <= den_r + vsgc_pkg::DEN_W'(mul_wide);
          S_ND1: nd_r <= vsgc_pkg::NUM_ACC_W'(mul_sat);
          S_ND2: nd_r <= nd_r + vsgc_pkg::NUM_ACC_W'(mul_sat);
          S_ND3: nd_r <= nd_r + vsgc_pkg::NUM_ACC_W'(mul_sat);
          S_NQ1: nq_r <= vsgc_pkg::NUM_ACC_W'(mul_sat);
          S_NQ2: nq_r <= nq_r + vsgc_pkg::NUM_ACC_W'(mul_sat);
          S_NQ3: nq_r <= nq_r - vsgc_pkg::NUM_ACC_W'(mul_sat);
          S_DD:  zd_r <= zval;
          S_DQ:  zq_r <= zval;
          S_FD1: t1_r <= mul_sat;
          S_FD2: pd_r <= vsgc_pkg::sadd(t1_r, mul_sat);
          S_FQ1: t1_r <= mul_sat;
          S_FQ2: pq_r <= vsgc_pkg::sadd(t1_r, mul_sat);
          S_SI:  si_r <= run_r ? vsgc_pkg::sadd(si_r, mul_sat) : 32'sd0;
          S_VI:  vi_r <= run_r ? vsgc_pkg::sadd(vi_r, mul_sat) : 32'sd0;
          S_PH:  pa_r <= vsgc_pkg::sadd(pa_wrap, mul_sat);
          S_AD:  crd_r <= mul_sat;
          S_AQ:  crq_r <= mul_sat;
          S_FS:  fs_r <= vsgc_pkg::sadd(ob_s, mul_sat);
          // remainder takes the sign of the angle
          S_MOD: ang_r <= theta_r[31] ? -rem_s : rem_s;
          default: ;
        endcase
      end
    end
  end

  vsgc_sermul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mul_req),
    .op_a     (op_a),
    .op_b     (op_b),
    .done     (mul_done),
    .res_wide (mul_wide),
    .res_sat  (mul_sat)
  );

  vsgc_serdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  vsgc_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cor_start),
    .angle  (ang_r),
    .done   (cor_done),
    .sine   (sine),
    .cosine (cosine)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `VSGC_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, st_r == S_VD, "accepted word did not start the sequence")
  `VSGC_ASSERT_SAME(a_out_from_seq, clk, rst_n, $rose(out_tvalid), $past(st_r) == S_OUT, "result raised outside the output step")
  `VSGC_ASSERT_SAME(a_zero_den, clk, rst_n, st_r == S_FD1 && den_r == '0, zd_r == '0, "zero impedance gave a nonzero reference")

endmodule
